@@ sv/tpc_pkg.sv @@
// tpc_pkg: shared types, constants and emit tables for the triangle plane clipper
// no dependencies
package tpc_pkg;

    localparam int NUM_FIELDS = 9;
    localparam int NUM_POS    = 3;
    localparam int NUM_COORD  = 5;
    localparam int COLOR_BITS = 16;
    localparam int TRI_VERTS  = 3;

    typedef logic [1:0] kind_t;
    typedef logic [2:0] src_t;
    typedef logic [2:0] emit_idx_t;
    typedef logic [1:0] reg_idx_t;

    localparam kind_t KIND_PASS = 2'd0;
    localparam kind_t KIND_ONE  = 2'd1;
    localparam kind_t KIND_TWO  = 2'd2;

    localparam src_t SRC_W0 = 3'd0;
    localparam src_t SRC_W1 = 3'd1;
    localparam src_t SRC_W2 = 3'd2;
    localparam src_t SRC_A  = 3'd3;
    localparam src_t SRC_B  = 3'd4;

    localparam reg_idx_t REG_NX     = 2'd0;
    localparam reg_idx_t REG_NY     = 2'd1;
    localparam reg_idx_t REG_NZ     = 2'd2;
    localparam reg_idx_t REG_OFFSET = 2'd3;

    function automatic src_t emit_src(kind_t k, emit_idx_t i);
        src_t s;
        s = SRC_W0;
        case (k)
            KIND_PASS:
            begin
                case (i)
                    3'd0:    s = SRC_W0;
                    3'd1:    s = SRC_W1;
                    default: s = SRC_W2;
                endcase
            end
            KIND_ONE:
            begin
                case (i)
                    3'd0:    s = SRC_W0;
                    3'd1:    s = SRC_A;
                    default: s = SRC_B;
                endcase
            end
            default:
            begin
                case (i)
                    3'd0:    s = SRC_W0;
                    3'd1:    s = SRC_W1;
                    3'd2:    s = SRC_A;
                    3'd3:    s = SRC_W0;
                    3'd4:    s = SRC_A;
                    default: s = SRC_B;
                endcase
            end
        endcase
        return s;
    endfunction

    function automatic emit_idx_t emit_last(kind_t k);
        emit_idx_t n;
        case (k)
            KIND_TWO: n = 3'd5;
            default:  n = 3'd2;
        endcase
        return n;
    endfunction

endpackage

@@ sv/tpc_queue.sv @@
// tpc_queue: two-entry job queue between classifier and clipper
// depends on nothing
module tpc_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wptr_reg;
    logic             rptr_reg;
    logic [1:0]       count_reg;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_wr   = wr && !full;
    assign do_rd   = rd && !empty;
    assign rd_data = mem_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (do_wr)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (do_rd)
            begin
                rptr_reg <= !rptr_reg;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

@@ sv/tpc_front.sv @@
// tpc_front: holds vertices, computes plane distances with one shared multiplier,
// classifies the triangle and pushes a rotated job; uses tpc_pkg
module tpc_front
    import tpc_pkg::*;
#(
    parameter int COORD_BITS = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    input  logic [NUM_FIELDS*((COORD_BITS > COLOR_BITS ? COORD_BITS : COLOR_BITS)+1)-1:0] in_vtx,
    output logic                                  busy,
    input  logic [COORD_BITS-1:0]                 nx,
    input  logic [COORD_BITS-1:0]                 ny,
    input  logic [COORD_BITS-1:0]                 nz,
    input  logic [COORD_BITS-1:0]                 offset,
    input  logic                                  q_full,
    output logic                                  q_wr,
    output logic [3*NUM_FIELDS*((COORD_BITS > COLOR_BITS ? COORD_BITS : COLOR_BITS)+1)
                  + 3*(2*COORD_BITS+2) + 1:0]    q_data
);

    localparam int VW    = (COORD_BITS > COLOR_BITS) ? COORD_BITS : COLOR_BITS;
    localparam int EW    = VW + 1;
    localparam int VTX_W = NUM_FIELDS * EW;
    localparam int DW    = 2 * COORD_BITS + 2;
    localparam int PW    = 2 * COORD_BITS;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_MUL   = 2'd1;
    localparam logic [1:0] ST_ACC   = 2'd2;
    localparam logic [1:0] ST_CLASS = 2'd3;

    logic [1:0]              st_reg;
    logic [1:0]              phase_reg;
    logic [VTX_W-1:0]        v_reg [TRI_VERTS];
    logic signed [DW-1:0]    d_reg [TRI_VERTS];
    logic [1:0]              vi_reg;
    logic [1:0]              ci_reg;
    logic signed [PW-1:0]    prod_reg;
    logic signed [DW-1:0]    acc_reg;

    logic [VTX_W-1:0]        cur_vtx;
    logic [COORD_BITS-1:0]   p_c;
    logic [COORD_BITS-1:0]   n_c;
    logic signed [PW-1:0]    sh;
    logic signed [DW-1:0]    acc_next;
    logic signed [DW-1:0]    off_ext;
    logic [TRI_VERTS-1:0]    neg;
    logic [1:0]              f0;
    kind_t                   kind;
    logic                    drop;
    logic [VTX_W-1:0]        w0;
    logic [VTX_W-1:0]        w1;
    logic [VTX_W-1:0]        w2;
    logic signed [DW-1:0]    e0;
    logic signed [DW-1:0]    e1;
    logic signed [DW-1:0]    e2;

    assign busy    = (st_reg != ST_IDLE);
    assign cur_vtx = v_reg[vi_reg];
    assign p_c     = cur_vtx[ci_reg*EW +: COORD_BITS];
    assign off_ext = {{(DW-COORD_BITS){offset[COORD_BITS-1]}}, offset};
    assign sh      = prod_reg >>> FRAC_BITS;
    assign acc_next = acc_reg + {{(DW-PW){sh[PW-1]}}, sh};

    always_comb
    begin
        case (ci_reg)
            2'd0:    n_c = nx;
            2'd1:    n_c = ny;
            default: n_c = nz;
        endcase
    end

    // first front vertex whose predecessor is behind
    always_comb
    begin
        neg[0] = d_reg[0][DW-1];
        neg[1] = d_reg[1][DW-1];
        neg[2] = d_reg[2][DW-1];
        if (neg[2] && !neg[0])
        begin
            f0 = 2'd0;
        end
        else if (neg[0] && !neg[1])
        begin
            f0 = 2'd1;
        end
        else if (neg[1] && !neg[2])
        begin
            f0 = 2'd2;
        end
        else
        begin
            f0 = 2'd0;
        end
        drop = &neg;
        case (f0)
            2'd1:
            begin
                w0 = v_reg[1]; w1 = v_reg[2]; w2 = v_reg[0];
                e0 = d_reg[1]; e1 = d_reg[2]; e2 = d_reg[0];
            end
            2'd2:
            begin
                w0 = v_reg[2]; w1 = v_reg[0]; w2 = v_reg[1];
                e0 = d_reg[2]; e1 = d_reg[0]; e2 = d_reg[1];
            end
            default:
            begin
                w0 = v_reg[0]; w1 = v_reg[1]; w2 = v_reg[2];
                e0 = d_reg[0]; e1 = d_reg[1]; e2 = d_reg[2];
            end
        endcase
        if (neg == '0)
        begin
            kind = KIND_PASS;
        end
        else if (!e1[DW-1])
        begin
            kind = KIND_TWO;
        end
        else
        begin
            kind = KIND_ONE;
        end
    end

    assign q_wr   = (st_reg == ST_CLASS) && !q_full && !drop;
    assign q_data = {kind, e2, e1, e0, w2, w1, w0};

    always_ff @(posedge clk)
    begin
        if (st_reg == ST_IDLE && in_valid)
        begin
            if (phase_reg == 2'd2)
            begin
                v_reg[2] <= in_vtx;
            end
            else if (phase_reg == 2'd1)
            begin
                v_reg[1] <= in_vtx;
            end
            else
            begin
                v_reg[0] <= in_vtx;
            end
        end
        if (st_reg == ST_MUL)
        begin
            prod_reg <= PW'($signed(n_c)) * PW'($signed(p_c));
        end
        if (st_reg == ST_ACC && ci_reg == 2'd2)
        begin
            d_reg[vi_reg] <= acc_next;
        end
        if (st_reg == ST_IDLE || (st_reg == ST_ACC && ci_reg == 2'd2))
        begin
            acc_reg <= off_ext;
        end
        else if (st_reg == ST_ACC)
        begin
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= ST_IDLE;
            phase_reg <= 2'd0;
            vi_reg    <= 2'd0;
            ci_reg    <= 2'd0;
        end
        else
        begin
            case (st_reg)
                ST_IDLE:
                begin
                    vi_reg <= 2'd0;
                    ci_reg <= 2'd0;
                    if (in_valid)
                    begin
                        if (phase_reg == 2'd2)
                        begin
                            phase_reg <= 2'd0;
                            st_reg    <= ST_MUL;
                        end
                        else if (phase_reg == 2'd1)
                        begin
                            phase_reg <= 2'd2;
                        end
                        else
                        begin
                            phase_reg <= 2'd1;
                        end
                    end
                end
                ST_MUL:
                begin
                    st_reg <= ST_ACC;
                end
                ST_ACC:
                begin
                    if (ci_reg == 2'd2)
                    begin
                        ci_reg <= 2'd0;
                        if (vi_reg == 2'd2)
                        begin
                            st_reg <= ST_CLASS;
                        end
                        else
                        begin
                            vi_reg <= vi_reg + 2'd1;
                            st_reg <= ST_MUL;
                        end
                    end
                    else
                    begin
                        ci_reg <= ci_reg + 2'd1;
                        st_reg <= ST_MUL;
                    end
                end
                default:
                begin
                    if (drop || !q_full)
                    begin
                        st_reg <= ST_IDLE;
                    end
                end
            endcase
        end
    end

endmodule

@@ sv/tpc_back.sv @@
// tpc_back: interpolates edge crossings (serial divider, shared multiplier)
// and emits the output vertex run into the result register; uses tpc_pkg
module tpc_back
    import tpc_pkg::*;
#(
    parameter int COORD_BITS = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  q_empty,
    input  logic [3*NUM_FIELDS*((COORD_BITS > COLOR_BITS ? COORD_BITS : COLOR_BITS)+1)
                  + 3*(2*COORD_BITS+2) + 1:0]    q_data,
    output logic                                  q_rd,
    output logic                                  empty,
    input  logic                                  pop,
    output logic [NUM_FIELDS*((COORD_BITS > COLOR_BITS ? COORD_BITS : COLOR_BITS)+1)-1:0] out_vtx,
    output logic                                  out_last
);

    localparam int VW    = (COORD_BITS > COLOR_BITS) ? COORD_BITS : COLOR_BITS;
    localparam int EW    = VW + 1;
    localparam int VTX_W = NUM_FIELDS * EW;
    localparam int DW    = 2 * COORD_BITS + 2;
    localparam int PW    = EW + FRAC_BITS + 2;
    localparam int SW    = $clog2(FRAC_BITS + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SETUP = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_MUL   = 3'd3;
    localparam logic [2:0] ST_ADD   = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;

    logic [2:0]              st_reg;
    logic [VTX_W-1:0]        w_reg [TRI_VERTS];
    logic signed [DW-1:0]    d_reg [TRI_VERTS];
    kind_t                   kind_reg;
    logic [VTX_W-1:0]        a_reg;
    logic [VTX_W-1:0]        b_reg;
    logic                    lerp_b_reg;
    logic [DW+1:0]           rem_reg;
    logic [DW:0]             den_reg;
    logic [FRAC_BITS-1:0]    fac_reg;
    logic [SW-1:0]           step_reg;
    logic [3:0]              fi_reg;
    logic signed [PW-1:0]    prod_reg;
    emit_idx_t               idx_reg;
    logic                    oval_reg;
    logic [VTX_W-1:0]        ovtx_reg;
    logic                    olast_reg;

    logic [VTX_W-1:0]        la;
    logic [VTX_W-1:0]        lb;
    logic signed [DW-1:0]    lda;
    logic signed [DW-1:0]    ldb;
    logic signed [EW-1:0]    fa;
    logic signed [EW-1:0]    fb;
    logic signed [EW:0]      diff;
    logic signed [PW-1:0]    sh;
    logic [EW-1:0]           res;
    logic [DW+1:0]           rem2;
    logic                    ge;
    src_t                    src;
    logic [VTX_W-1:0]        evtx;
    logic                    can_load;
    logic                    is_last;

    assign empty    = !oval_reg;
    assign out_vtx  = ovtx_reg;
    assign out_last = olast_reg;
    assign q_rd     = (st_reg == ST_IDLE) && !q_empty;

    always_comb
    begin
        if (lerp_b_reg)
        begin
            la = w_reg[0]; lb = w_reg[2]; lda = d_reg[0]; ldb = d_reg[2];
        end
        else if (kind_reg == KIND_ONE)
        begin
            la = w_reg[0]; lb = w_reg[1]; lda = d_reg[0]; ldb = d_reg[1];
        end
        else
        begin
            la = w_reg[1]; lb = w_reg[2]; lda = d_reg[1]; ldb = d_reg[2];
        end
    end

    assign fa   = la[fi_reg*EW +: EW];
    assign fb   = lb[fi_reg*EW +: EW];
    assign diff = {fb[EW-1], fb} - {fa[EW-1], fa};
    assign sh   = prod_reg >>> FRAC_BITS;
    assign res  = fa + sh[EW-1:0];
    assign rem2 = {rem_reg[DW:0], 1'b0};
    assign ge   = (rem2 >= {1'b0, den_reg});

    always_comb
    begin
        src = emit_src(kind_reg, idx_reg);
        case (src)
            SRC_W1:  evtx = w_reg[1];
            SRC_W2:  evtx = w_reg[2];
            SRC_A:   evtx = a_reg;
            SRC_B:   evtx = b_reg;
            default: evtx = w_reg[0];
        endcase
    end

    assign can_load = (st_reg == ST_EMIT) && (!oval_reg || pop);
    assign is_last  = (idx_reg == emit_last(kind_reg));

    always_ff @(posedge clk)
    begin
        if (q_rd)
        begin
            {kind_reg, d_reg[2], d_reg[1], d_reg[0], w_reg[2], w_reg[1], w_reg[0]} <= q_data;
        end
        if (st_reg == ST_SETUP)
        begin
            rem_reg <= {2'b00, lda};
            den_reg <= {lda[DW-1], lda} - {ldb[DW-1], ldb};
            fac_reg <= '0;
        end
        if (st_reg == ST_DIV)
        begin
            rem_reg <= ge ? (rem2 - {1'b0, den_reg}) : rem2;
            fac_reg <= {fac_reg[FRAC_BITS-2:0], ge};
        end
        if (st_reg == ST_MUL)
        begin
            prod_reg <= PW'(diff) * PW'($signed({1'b0, fac_reg}));
        end
        if (st_reg == ST_ADD)
        begin
            if (lerp_b_reg)
            begin
                b_reg[fi_reg*EW +: EW] <= res;
            end
            else
            begin
                a_reg[fi_reg*EW +: EW] <= res;
            end
        end
        if (can_load)
        begin
            ovtx_reg  <= evtx;
            olast_reg <= is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= ST_IDLE;
            lerp_b_reg <= 1'b0;
            step_reg   <= '0;
            fi_reg     <= 4'd0;
            idx_reg    <= 3'd0;
            oval_reg   <= 1'b0;
        end
        else
        begin
            if (can_load)
            begin
                oval_reg <= 1'b1;
            end
            else if (pop)
            begin
                oval_reg <= 1'b0;
            end
            case (st_reg)
                ST_IDLE:
                begin
                    lerp_b_reg <= 1'b0;
                    idx_reg    <= 3'd0;
                    if (!q_empty)
                    begin
                        st_reg <= (q_data[$bits(q_data)-1 -: 2] == KIND_PASS) ? ST_EMIT
                                                                             : ST_SETUP;
                    end
                end
                ST_SETUP:
                begin
                    step_reg <= SW'(FRAC_BITS - 1);
                    st_reg   <= ST_DIV;
                end
                ST_DIV:
                begin
                    fi_reg <= 4'd0;
                    if (step_reg == '0)
                    begin
                        st_reg <= ST_MUL;
                    end
                    else
                    begin
                        step_reg <= step_reg - 1'b1;
                    end
                end
                ST_MUL:
                begin
                    st_reg <= ST_ADD;
                end
                ST_ADD:
                begin
                    if (fi_reg == 4'(NUM_FIELDS - 1))
                    begin
                        if (lerp_b_reg)
                        begin
                            st_reg <= ST_EMIT;
                        end
                        else
                        begin
                            lerp_b_reg <= 1'b1;
                            st_reg     <= ST_SETUP;
                        end
                    end
                    else
                    begin
                        fi_reg <= fi_reg + 4'd1;
                        st_reg <= ST_MUL;
                    end
                end
                ST_EMIT:
                begin
                    if (can_load)
                    begin
                        if (is_last)
                        begin
                            st_reg <= ST_IDLE;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + 3'd1;
                        end
                    end
                end
                default:
                begin
                    st_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

@@ sv/triangle_plane_clip.sv @@
// triangle_plane_clip: clips a vertex-serial triangle list against one plane.
// path from third vertex transfer to first result transfer: nine distance products on the
// shared multiplier, classify, job queue, output register; clipped triangles add two serial
// divides and nine lerp products each. throughput: first two vertices one per cycle, the
// third holds full while its distances are computed and classified (longer while the job
// queue is full); one result transfer per cycle while emitting and pop is held. reset: phase,
// job queue and output register emptied, plane (0, 1.0, 0) offset 0; held vertices undefined
module triangle_plane_clip
    import tpc_pkg::*;
#(
    parameter int COORD_BITS = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [COORD_BITS-1:0]        pos_x,
    input  logic [COORD_BITS-1:0]        pos_y,
    input  logic [COORD_BITS-1:0]        pos_z,
    input  logic [COORD_BITS-1:0]        tex_u,
    input  logic [COORD_BITS-1:0]        tex_v,
    input  logic [COLOR_BITS-1:0]        col_r,
    input  logic [COLOR_BITS-1:0]        col_g,
    input  logic [COLOR_BITS-1:0]        col_b,
    input  logic [COLOR_BITS-1:0]        col_a,
    output logic                         empty,
    input  logic                         pop,
    output logic [COORD_BITS-1:0]        out_x,
    output logic [COORD_BITS-1:0]        out_y,
    output logic [COORD_BITS-1:0]        out_z,
    output logic [COORD_BITS-1:0]        out_u,
    output logic [COORD_BITS-1:0]        out_v,
    output logic [COLOR_BITS-1:0]        out_r,
    output logic [COLOR_BITS-1:0]        out_g,
    output logic [COLOR_BITS-1:0]        out_b,
    output logic [COLOR_BITS-1:0]        out_a,
    output logic                         run_last,
    input  logic                         cfg_we,
    input  reg_idx_t                     cfg_addr,
    input  logic [COORD_BITS-1:0]        cfg_data
);

    localparam int VW    = (COORD_BITS > COLOR_BITS) ? COORD_BITS : COLOR_BITS;
    localparam int EW    = VW + 1;
    localparam int VTX_W = NUM_FIELDS * EW;
    localparam int DW    = 2 * COORD_BITS + 2;
    localparam int JOB_W = 3 * VTX_W + 3 * DW + 2;

    logic [COORD_BITS-1:0] nx_reg;
    logic [COORD_BITS-1:0] ny_reg;
    logic [COORD_BITS-1:0] nz_reg;
    logic [COORD_BITS-1:0] off_reg;
    logic [COORD_BITS-1:0] one_q;

    logic [VTX_W-1:0]      in_vtx;
    logic [VTX_W-1:0]      out_vtx;
    logic                  front_busy;
    logic                  q_wr;
    logic                  q_full;
    logic                  q_rd;
    logic                  q_empty;
    logic [JOB_W-1:0]      q_wdata;
    logic [JOB_W-1:0]      q_rdata;

    assign one_q = {{(COORD_BITS-1){1'b0}}, 1'b1} << FRAC_BITS;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nx_reg  <= '0;
            ny_reg  <= one_q;
            nz_reg  <= '0;
            off_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_NX:  nx_reg  <= cfg_data;
                REG_NY:  ny_reg  <= cfg_data;
                REG_NZ:  nz_reg  <= cfg_data;
                default: off_reg <= cfg_data;
            endcase
        end
    end

    // fields held sign or zero extended to a common width
    assign in_vtx[0*EW +: EW] = {{(EW-COORD_BITS){pos_x[COORD_BITS-1]}}, pos_x};
    assign in_vtx[1*EW +: EW] = {{(EW-COORD_BITS){pos_y[COORD_BITS-1]}}, pos_y};
    assign in_vtx[2*EW +: EW] = {{(EW-COORD_BITS){pos_z[COORD_BITS-1]}}, pos_z};
    assign in_vtx[3*EW +: EW] = {{(EW-COORD_BITS){tex_u[COORD_BITS-1]}}, tex_u};
    assign in_vtx[4*EW +: EW] = {{(EW-COORD_BITS){tex_v[COORD_BITS-1]}}, tex_v};
    assign in_vtx[5*EW +: EW] = {{(EW-COLOR_BITS){1'b0}}, col_r};
    assign in_vtx[6*EW +: EW] = {{(EW-COLOR_BITS){1'b0}}, col_g};
    assign in_vtx[7*EW +: EW] = {{(EW-COLOR_BITS){1'b0}}, col_b};
    assign in_vtx[8*EW +: EW] = {{(EW-COLOR_BITS){1'b0}}, col_a};

    assign full = front_busy;

    tpc_front #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (push && !front_busy),
        .in_vtx   (in_vtx),
        .busy     (front_busy),
        .nx       (nx_reg),
        .ny       (ny_reg),
        .nz       (nz_reg),
        .offset   (off_reg),
        .q_full   (q_full),
        .q_wr     (q_wr),
        .q_data   (q_wdata)
    );

    tpc_queue #(
        .WIDTH (JOB_W)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_wr),
        .wr_data (q_wdata),
        .full    (q_full),
        .rd      (q_rd),
        .rd_data (q_rdata),
        .empty   (q_empty)
    );

    tpc_back #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_data   (q_rdata),
        .q_rd     (q_rd),
        .empty    (empty),
        .pop      (pop),
        .out_vtx  (out_vtx),
        .out_last (run_last)
    );

    assign out_x = out_vtx[0*EW +: COORD_BITS];
    assign out_y = out_vtx[1*EW +: COORD_BITS];
    assign out_z = out_vtx[2*EW +: COORD_BITS];
    assign out_u = out_vtx[3*EW +: COORD_BITS];
    assign out_v = out_vtx[4*EW +: COORD_BITS];
    assign out_r = out_vtx[5*EW +: COLOR_BITS];
    assign out_g = out_vtx[6*EW +: COLOR_BITS];
    assign out_b = out_vtx[7*EW +: COLOR_BITS];
    assign out_a = out_vtx[8*EW +: COLOR_BITS];

endmodule
